[src/rau_pkg.sv]
// ============================================================================
// rau_pkg: shared types and constants for the rational arithmetic unit
// Request and result payloads, operation codes and the sequencer states.
// ============================================================================
`default_nettype none
package rau_pkg;

  localparam int unsigned MagBits = 64;

  typedef enum logic [2:0] {
    OP_NORM = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_LESS = 3'd5,
    OP_EQ   = 3'd6,
    OP_NONE = 3'd7
  } op_e;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } req_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic               compare_true;
    logic               zero_divisor;
    logic               overflow;
  } rsp_t;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LOAD_A,    // start gcd on a
    ST_GCD,       // remainder loop running
    ST_DIVN,      // num / g
    ST_DIVD,      // den / g
    ST_NEXT,      // decide after one reduction
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_COMBINE,
    ST_FINISH,
    ST_OUT
  } state_e;

  // Divider requests and replies travel as a pair of structs
  typedef struct packed {
    logic              start;
    logic [MagBits-1:0] dividend;
    logic [MagBits-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [MagBits-1:0] quot;
    logic [MagBits-1:0] rem;
  } div_rsp_t;

endpackage
`default_nettype wire

[src/rau_divider.sv]
// ============================================================================
// rau_divider: shared 64-bit unsigned restoring divider
// One quotient bit per cycle; gives quotient and remainder when done.
// ============================================================================
`default_nettype none
module rau_divider (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rau_pkg::div_req_t req_i,
  output rau_pkg::div_rsp_t      rsp_o
);
  import rau_pkg::*;

  localparam int unsigned CntBits = $clog2(MagBits + 1);

  logic               busy_q, busy_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic [MagBits-1:0] quo_q, quo_d;
  logic [MagBits-1:0] rem_q, rem_d;
  logic [MagBits-1:0] dsr_q, dsr_d;
  logic               done_q, done_d;
  logic [MagBits:0]   trial;

  // Shift one dividend bit into the partial remainder and try a subtract
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[MagBits-1]} - {1'b0, dsr_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntBits'(MagBits);
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      if (!trial[MagBits]) begin
        rem_d = trial[MagBits-1:0];
        quo_d = {quo_q[MagBits-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[MagBits-2:0], quo_q[MagBits-1]};
        quo_d = {quo_q[MagBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule
`default_nettype wire

[src/rational_arithmetic_unit.sv]
// ============================================================================
// rational_arithmetic_unit: exact fraction arithmetic with gcd reduction
// Normalizes, adds, subtracts, multiplies, divides and compares fractions.
// ============================================================================
//
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+-----------------------
//  req     | in        | req_valid_i/stall| rau_pkg::req_t
//  rsp     | out       | rsp_valid_o/stall| rau_pkg::rsp_t
//
// One request at a time; the request side stalls from acceptance until the
// result is taken. Each remainder step and each divide by the gcd is one pass
// of the shared 64-bit divider. Zero operands skip their reduction, and an
// unknown operation or a zero denominator is answered straight from the load
// state, without a reduction.
`default_nettype none
module rational_arithmetic_unit #(
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           req_valid_i,
  output logic                req_stall_o,
  input  wire rau_pkg::req_t  req_i,
  output logic                rsp_valid_o,
  input  wire logic           rsp_stall_i,
  output rau_pkg::rsp_t       rsp_o
);
  import rau_pkg::*;

  localparam int unsigned W = WORD_BITS;
  localparam logic [MagBits-1:0] Limit = MagBits'(1) << (W - 1);

  state_e state_q, state_d;
  logic [2:0] op_q, op_d;
  // Operands as sign and magnitude (magnitudes up to 2^(W-1))
  logic an_q, an_d, bn_q, bn_d;
  logic [MagBits-1:0] anum_q, anum_d, aden_q, aden_d, bnum_q, bnum_d, bden_q, bden_d;
  // Working fraction under reduction and gcd registers
  logic rn_q, rn_d;
  logic [MagBits-1:0] rnum_q, rnum_d, rden_q, rden_d;
  logic [MagBits-1:0] gx_q, gx_d, gy_q, gy_d;
  logic [1:0] which_q, which_d;   // 0 a, 1 b, 2 result
  logic dstart_q, dstart_d;
  logic [MagBits-1:0] p_q, p_d, q_q, q_d, d_q, d_d;
  rsp_t rsp_q, rsp_d;
  div_req_t dreq;
  div_rsp_t drsp;
  logic [31:0] mul_x, mul_y;
  logic [MagBits-1:0] mul_p;
  logic [MagBits-1:0] sum_mag;
  logic sum_neg, less_v, ovf;

  // Low W bits as two's complement to sign and magnitude
  function automatic logic [MagBits:0] to_sm(input logic [31:0] raw);
    logic [MagBits-1:0] full, v;
    logic neg;
    full = MagBits'(1) << W;
    v    = MagBits'(raw) & (full - 1'b1);
    neg  = v[W-1];
    return {neg, neg ? (full - v) : v};
  endfunction

  rau_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  assign mul_p = MagBits'(mul_x) * MagBits'(mul_y);

  // Sequence loads, gcd loops, products and the final check
  always_comb begin
    logic [MagBits:0] sa, sb, sc, sd;
    state_d = state_q;  op_d = op_q;
    an_d = an_q; bn_d = bn_q; anum_d = anum_q; aden_d = aden_q;
    bnum_d = bnum_q; bden_d = bden_q;
    rn_d = rn_q; rnum_d = rnum_q; rden_d = rden_q;
    gx_d = gx_q; gy_d = gy_q; which_d = which_q; dstart_d = 1'b0;
    p_d = p_q; q_d = q_q; d_d = d_q; rsp_d = rsp_q;
    dreq.start = dstart_q; dreq.dividend = gx_q; dreq.divisor = gy_q;
    mul_x = '0; mul_y = '0;
    sum_neg = 1'b0; sum_mag = '0; less_v = 1'b0; ovf = 1'b0;
    sa = to_sm(req_i.a_num); sb = to_sm(req_i.a_den);
    sc = to_sm(req_i.b_num); sd = to_sm(req_i.b_den);
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          op_d = req_i.operation;
          an_d = sa[MagBits] ^ sb[MagBits]; anum_d = sa[MagBits-1:0];
          aden_d = sb[MagBits-1:0];
          bn_d = sc[MagBits] ^ sd[MagBits]; bnum_d = sc[MagBits-1:0];
          bden_d = sd[MagBits-1:0];
          rsp_d = '0;
          state_d = ST_LOAD_A;
        end
      end
      ST_LOAD_A: begin
        if (op_q == OP_NONE) begin
          state_d = ST_OUT;
        end else if (aden_q == '0 || (op_q != OP_NORM && bden_q == '0)) begin
          rsp_d.zero_divisor = 1'b1;
          state_d = ST_OUT;
        end else begin
          which_d = 2'd0;
          rn_d = an_q; rnum_d = anum_q; rden_d = aden_q;
          state_d = ST_NEXT;
          if (anum_q != '0) begin
            gx_d = anum_q; gy_d = aden_q; dstart_d = 1'b1; state_d = ST_GCD;
          end
        end
      end
      ST_GCD: begin
        if (drsp.done) begin
          if (drsp.rem == '0) begin
            // gy holds the gcd; divide numerator by it
            gx_d = rnum_q; dstart_d = 1'b1; state_d = ST_DIVN;
          end else begin
            gx_d = gy_q; gy_d = drsp.rem; dstart_d = 1'b1;
          end
        end
      end
      ST_DIVN: begin
        if (drsp.done) begin
          rnum_d = drsp.quot; gx_d = rden_q; dstart_d = 1'b1; state_d = ST_DIVD;
        end
      end
      ST_DIVD: begin
        if (drsp.done) begin
          rden_d = drsp.quot; state_d = ST_NEXT;
        end
      end
      ST_NEXT: begin
        // zero becomes 0/1
        if (rnum_q == '0) begin
          rn_d = 1'b0; rden_d = MagBits'(1);
        end
        unique case (which_q)
          2'd0: begin
            an_d = (rnum_q == '0) ? 1'b0 : rn_q; anum_d = rnum_q;
            aden_d = (rnum_q == '0) ? MagBits'(1) : rden_q;
            if (op_q == OP_NORM) begin
              state_d = ST_FINISH;
            end else begin
              which_d = 2'd1;
              rn_d = bn_q; rnum_d = bnum_q; rden_d = bden_q;
              state_d = ST_NEXT;
              if (bnum_q != '0) begin
                gx_d = bnum_q; gy_d = bden_q; dstart_d = 1'b1; state_d = ST_GCD;
              end
            end
          end
          2'd1: begin
            bn_d = (rnum_q == '0) ? 1'b0 : rn_q; bnum_d = rnum_q;
            bden_d = (rnum_q == '0) ? MagBits'(1) : rden_q;
            state_d = ST_MUL1;
          end
          default: state_d = ST_FINISH;
        endcase
      end
      ST_MUL1: begin
        mul_x = anum_q[31:0]; mul_y = bden_q[31:0]; p_d = mul_p;
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        mul_x = bnum_q[31:0]; mul_y = aden_q[31:0]; q_d = mul_p;
        state_d = ST_MUL3;
      end
      ST_MUL3: begin
        mul_x = aden_q[31:0]; mul_y = bden_q[31:0]; d_d = mul_p;
        if (op_q == OP_MUL) begin
          mul_x = anum_q[31:0]; mul_y = bnum_q[31:0]; p_d = mul_p;
        end else if (op_q == OP_DIV) begin
          mul_x = aden_q[31:0]; mul_y = bnum_q[31:0]; d_d = mul_p;
        end
        if (op_q == OP_MUL) begin
          state_d = ST_MUL1;  // den product is formed in ST_COMBINE
          d_d = d_q;
          state_d = ST_COMBINE;
        end else begin
          state_d = ST_COMBINE;
        end
      end
      ST_COMBINE: begin
        // Signed add of cross products
        if (an_q == (bn_q ^ (op_q == OP_SUB))) begin
          sum_neg = an_q; sum_mag = p_q + q_q;
        end else if (p_q >= q_q) begin
          sum_neg = an_q; sum_mag = p_q - q_q;
        end else begin
          sum_neg = bn_q ^ (op_q == OP_SUB); sum_mag = q_q - p_q;
        end
        if (an_q != bn_q) less_v = an_q;
        else if (an_q) less_v = p_q > q_q;
        else less_v = p_q < q_q;
        which_d = 2'd2;
        priority case (op_q)
          OP_ADD, OP_SUB: begin
            rn_d = (sum_mag == '0) ? 1'b0 : sum_neg; rnum_d = sum_mag;
            mul_x = aden_q[31:0]; mul_y = bden_q[31:0]; rden_d = mul_p;
          end
          OP_MUL: begin
            rn_d = an_q ^ bn_q; rnum_d = p_q;
            mul_x = aden_q[31:0]; mul_y = bden_q[31:0]; rden_d = mul_p;
          end
          OP_DIV: begin
            rn_d = an_q ^ bn_q; rnum_d = p_q; rden_d = d_q;
          end
          default: ;
        endcase
        if (op_q == OP_LESS) begin
          rsp_d.compare_true = less_v; state_d = ST_OUT;
        end else if (op_q == OP_EQ) begin
          rsp_d.compare_true = (an_q == bn_q) && (anum_q == bnum_q)
                               && (aden_q == bden_q);
          state_d = ST_OUT;
        end else if (op_q == OP_DIV && bnum_q == '0) begin
          rsp_d.zero_divisor = 1'b1; state_d = ST_OUT;
        end else begin
          state_d = ST_NEXT;
          if (rnum_d != '0) begin
            gx_d = rnum_d; gy_d = rden_d; dstart_d = 1'b1; state_d = ST_GCD;
          end
        end
      end
      ST_FINISH: begin
        ovf = (rn_q ? (rnum_q > Limit) : (rnum_q > Limit - 1'b1))
              || (rden_q > Limit - 1'b1);
        if (ovf) begin
          rsp_d.overflow = 1'b1;
        end else begin
          rsp_d.res_num = rn_q ? (32'd0 - rnum_q[31:0]) : rnum_q[31:0];
          rsp_d.res_den = rden_q[30:0];
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!rsp_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    // In the multiply flow the first product is the numerator product
    if (state_q == ST_MUL1 && op_q == OP_MUL) begin
      mul_x = anum_q[31:0]; mul_y = bnum_q[31:0]; p_d = mul_p;
    end
    if (state_q == ST_MUL1 && op_q == OP_DIV) begin
      p_d = mul_p;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      dstart_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      dstart_q <= dstart_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    an_q <= an_d; bn_q <= bn_d;
    anum_q <= anum_d; aden_q <= aden_d; bnum_q <= bnum_d; bden_q <= bden_d;
    rn_q <= rn_d; rnum_q <= rnum_d; rden_q <= rden_d;
    gx_q <= gx_d; gy_q <= gy_d; which_q <= which_d;
    p_q <= p_d; q_q <= q_d; d_q <= d_d;
    rsp_q <= rsp_d;
  end

  assign req_stall_o = (state_q != ST_IDLE);
  assign rsp_valid_o = (state_q == ST_OUT);
  assign rsp_o       = rsp_q;

endmodule
`default_nettype wire
